// File: rtl/core/vpd_pkg.sv
// ---------------------------------------------------------------------------
// vpd_pkg: shared types and constants of the varint packet deframer
// Phase codes, result kinds, error codes and the state and result records.
// ---------------------------------------------------------------------------
`default_nettype none

package vpd_pkg;

  localparam int unsigned LenW   = 31;
  localparam int unsigned AccW   = 32;
  localparam int unsigned GcntW  = 3;
  localparam int unsigned PhaseW = 2;

  // phase codes
  localparam logic [PhaseW-1:0] PH_LEN  = 2'd0;
  localparam logic [PhaseW-1:0] PH_ID   = 2'd1;
  localparam logic [PhaseW-1:0] PH_PAY  = 2'd2;
  localparam logic [PhaseW-1:0] PH_SKIP = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_HDR = 2'd0;
  localparam logic [1:0] KIND_PAY = 2'd1;
  localparam logic [1:0] KIND_ERR = 2'd2;

  // error codes
  localparam logic [1:0] ERR_LEN_OVF   = 2'd0;
  localparam logic [1:0] ERR_LEN_RANGE = 2'd1;
  localparam logic [1:0] ERR_ID_OVF    = 2'd2;
  localparam logic [1:0] ERR_ID_TRUNC  = 2'd3;

  // a varint carries at most this many groups
  localparam logic [GcntW-1:0] GRP_LIMIT = 3'd5;

  localparam logic [LenW-1:0] MAX_LEN_RST = 31'd2097151;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic [AccW-1:0]   accum;
    logic [GcntW-1:0]  gcnt;
    logic [LenW-1:0]   left;
  } state_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic signed [31:0] frame_id;
    logic [LenW-1:0]   body_len;
    logic [7:0]        data;
    logic              last;
    logic [1:0]        error_code;
  } result_t;

endpackage : vpd_pkg

`default_nettype wire

// File: rtl/core/varint_packet_deframer_core.sv
// ---------------------------------------------------------------------------
// varint_packet_deframer_core: length-prefixed varint frame splitter
// Input channel in_*: one received byte per beat. Each frame opens with a
// varint total length, then a varint packet id, then the payload bytes.
// Output channel out_*: one beat per result; out_tuser is the kind (header,
// payload byte, error) and out_tlast marks the final payload byte or a
// header with empty payload. Error beats carry the error code.
// Config channel cfg_*: writes the maximum frame length; always ready.
// Write it only while no byte is in flight.
// Throughput: one byte per cycle while the skid stage is empty; when it
// holds a result, in_tready drops. A byte goes from the input register
// through the combinational decode into the result register or skid stage.
// Reset (rst_n low at a clock edge) empties the input, result and skid
// registers, awaits a length and sets the maximum frame length to 2097151.
// When the receiver stalls, one more result goes into the skid stage and
// then in_tready drops until the receiver takes a beat.
// ---------------------------------------------------------------------------
`default_nettype none

module varint_packet_deframer_core
  import vpd_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  // in_tdata: [7:0] rx_byte
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [7:0]      in_tdata,
  // out_tdata: [31:0] frame_id, [62:32] body_len, [70:63] data,
  //            [72:71] error_code, [79:73] zero
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [79:0]     out_tdata,
  // out_tuser: [1:0] kind
  output logic [1:0]      out_tuser,
  output logic            out_tlast,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [LenW-1:0] cfg_data
);

  logic            in_valid_r;
  logic [7:0]      in_byte_r;
  logic [LenW-1:0] max_len_r;
  state_t          st_r;
  state_t          st_nxt;
  logic            res_valid;
  result_t         res;
  logic            can_push;
  logic            fire;
  result_t         out_res;

  assign fire      = in_valid_r && can_push;
  assign in_tready = !in_valid_r || fire;
  assign cfg_ready = 1'b1;

  vpd_step u_step (
    .cur       (st_r),
    .rx_byte   (in_byte_r),
    .max_len   (max_len_r),
    .nxt       (st_nxt),
    .res_valid (res_valid),
    .res       (res)
  );

  vpd_out_buf u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fire && res_valid),
    .push_data (res),
    .can_push  (can_push),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_res)
  );

  assign out_tdata = {7'd0, out_res.error_code, out_res.data,
                      out_res.body_len, out_res.frame_id};
  assign out_tuser = out_res.kind;
  assign out_tlast = out_res.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      st_r       <= '0;
      max_len_r  <= MAX_LEN_RST;
    end else begin
      if (in_tvalid && in_tready) begin
        in_valid_r <= 1'b1;
      end else if (fire) begin
        in_valid_r <= 1'b0;
      end
      if (fire) st_r <= st_nxt;
      if (cfg_valid) max_len_r <= cfg_data;
    end
    if (in_tvalid && in_tready) in_byte_r <= in_tdata;
  end

`ifndef ASSERT_OFF
  a_frame_open: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.phase != PH_LEN) |-> (st_r.left != '0))
    else $error("inside a frame with no bytes left");

  a_len_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.phase == PH_LEN) |-> (st_r.left == '0))
    else $error("byte count left over while waiting for a length");

  a_group_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.gcnt < GRP_LIMIT)
    else $error("varint group count past its limit");

  a_err_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == KIND_ERR)) |-> !out_tlast)
    else $error("error beat flagged as last");
`endif

endmodule : varint_packet_deframer_core

`default_nettype wire

// File: rtl/core/vpd_step.sv
// ---------------------------------------------------------------------------
// vpd_step: per-byte decode of the deframer
// Takes the current state and one byte, gives the next state and at most one
// result. Purely combinational; the caller registers both sides.
// ---------------------------------------------------------------------------
`default_nettype none

module vpd_step
  import vpd_pkg::*;
(
  input  state_t          cur,
  input  logic [7:0]      rx_byte,
  input  logic [LenW-1:0] max_len,
  output state_t          nxt,
  output logic            res_valid,
  output result_t         res
);

  // place one 7-bit group at its offset; groups past the fifth add nothing
  function automatic logic [AccW-1:0] group_bits(input logic [GcntW-1:0] gc,
                                                 input logic [6:0] g);
    logic [AccW-1:0] r;
    r = '0;
    unique case (gc)
      3'd0:    r = {25'd0, g};
      3'd1:    r = {18'd0, g, 7'd0};
      3'd2:    r = {11'd0, g, 14'd0};
      3'd3:    r = {4'd0, g, 21'd0};
      3'd4:    r = {g[3:0], 28'd0};
      default: r = '0;
    endcase
    return r;
  endfunction

  logic            more;
  logic [AccW-1:0] acc;
  logic [GcntW-1:0] gc_inc;
  logic [LenW-1:0] left_dec;

  assign more     = rx_byte[7];
  assign acc      = cur.accum | group_bits(cur.gcnt, rx_byte[6:0]);
  assign gc_inc   = GcntW'(cur.gcnt + 3'd1);
  assign left_dec = (cur.left != '0) ? LenW'(cur.left - 31'd1) : cur.left;

  always_comb begin
    nxt       = cur;
    res_valid = 1'b0;
    res       = '0;
    unique case (cur.phase)
      PH_LEN: begin
        if (more) begin
          if (gc_inc >= GRP_LIMIT) begin
            nxt            = '0;
            res_valid      = 1'b1;
            res.kind       = KIND_ERR;
            res.error_code = ERR_LEN_OVF;
          end else begin
            nxt.accum = acc;
            nxt.gcnt  = gc_inc;
          end
        end else begin
          nxt = '0;
          if (acc[AccW-1] || (acc[LenW-1:0] > max_len)) begin
            res_valid      = 1'b1;
            res.kind       = KIND_ERR;
            res.error_code = ERR_LEN_RANGE;
          end else if (acc == '0) begin
            // empty frame has no room for an id
            res_valid      = 1'b1;
            res.kind       = KIND_ERR;
            res.error_code = ERR_ID_TRUNC;
          end else begin
            nxt.left  = acc[LenW-1:0];
            nxt.phase = PH_ID;
          end
        end
      end
      PH_ID: begin
        if (more) begin
          if (gc_inc >= GRP_LIMIT) begin
            // overflow wins over frame end; drop the rest of the frame
            nxt            = '0;
            res_valid      = 1'b1;
            res.kind       = KIND_ERR;
            res.error_code = ERR_ID_OVF;
            if (left_dec != '0) begin
              nxt.phase = PH_SKIP;
              nxt.left  = left_dec;
            end
          end else if (left_dec == '0) begin
            nxt            = '0;
            res_valid      = 1'b1;
            res.kind       = KIND_ERR;
            res.error_code = ERR_ID_TRUNC;
          end else begin
            nxt.accum = acc;
            nxt.gcnt  = gc_inc;
            nxt.left  = left_dec;
          end
        end else begin
          nxt          = '0;
          nxt.left     = left_dec;
          nxt.phase    = (left_dec == '0) ? PH_LEN : PH_PAY;
          res_valid    = 1'b1;
          res.kind     = KIND_HDR;
          res.frame_id = acc;
          res.body_len = left_dec;
          res.last     = (left_dec == '0);
        end
      end
      PH_PAY: begin
        nxt.left  = left_dec;
        if (left_dec == '0) nxt.phase = PH_LEN;
        res_valid = 1'b1;
        res.kind  = KIND_PAY;
        res.data  = rx_byte;
        res.last  = (left_dec == '0);
      end
      PH_SKIP: begin
        nxt.left = left_dec;
        if (left_dec == '0) nxt.phase = PH_LEN;
      end
      default: nxt = cur;
    endcase
  end

endmodule : vpd_step

`default_nettype wire

// File: rtl/core/vpd_out_buf.sv
// ---------------------------------------------------------------------------
// vpd_out_buf: result register with skid stage
// Holds up to two results so the decode side can push one more result
// after the receiver stalls.
// ---------------------------------------------------------------------------
`default_nettype none

module vpd_out_buf
  import vpd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  output logic    can_push,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    out_valid_r, out_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t out_data_r, out_data_nxt;
  result_t skid_data_r, skid_data_nxt;
  logic    pop;

  assign pop       = out_valid_r && out_ready;
  assign can_push  = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        // advance the skid beat, park a new one behind it
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = push;
        skid_data_nxt  = push_data;
      end else begin
        out_valid_nxt = push;
        out_data_nxt  = push_data;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

`ifndef ASSERT_OFF
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a beat while the output register is empty");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_data_r)))
    else $error("stalled result changed");
`endif

endmodule : vpd_out_buf

`default_nettype wire
